// ===== design/gbw_pkg.sv =====
// Package for the gaussian blur window block: widths, register indexes,
// window geometry. No dependencies.
package gbw_pkg;
  localparam int MaxRadius = 3;
  localparam int MaxWidth  = 1024;
  localparam int Lines     = 2 * MaxRadius;
  localparam int Win       = 2 * MaxRadius + 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 12;
  localparam int LineW     = 8 * Lines;

  typedef enum logic [2:0] {
    RegRadius = 3'd0, RegW0 = 3'd1, RegW1 = 3'd2, RegW2 = 3'd3, RegW3 = 3'd4,
    RegWidth = 3'd5, RegHeight = 3'd6, RegNone = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  r;
    logic [10:0] w;
    logic [12:0] h;
  } geom_t;
endpackage

// ===== design/gbw_line_mem.sv =====
// Line store: one word per column holding all stored lines.
// Synchronous memory with a registered read port. Uses gbw_pkg.
module gbw_line_mem import gbw_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ColW-1:0]  waddr_i,
  input  logic [LineW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [ColW-1:0]  raddr_i,
  output logic [LineW-1:0] rdata_o
);
  logic [LineW-1:0] mem [MaxWidth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/gaussian_blur_window.sv =====
// Top level of the gaussian blur window: position tracking, line store
// read-modify-write, window, and a sequential multiply-accumulate.
// Depends on gbw_pkg and gbw_line_mem.
//
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tdata pixel, tuser frame_start
//  m_axis  | out | tvalid/tready      | tdata blurred,row,col; tlast last
//  cfg     | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A word passes the states accept, read and shift; one that yields a result
// then steps through the (2r+1)^2 taps of the single 32x8 multiply-accumulate
// and drains its pipeline. The line store is cleared by a pass over all 1024
// columns after reset; no input word is taken meanwhile. The output register
// holds a result until taken; the next word is accepted while it waits, and the
// drain stalls only if the register is still full when the next result is ready.
module gaussian_blur_window import gbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] blurred, [19:8] centre_row, [29:20] centre_col
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  typedef enum logic [5:0] {
    StClr = 6'b000001, StIdle = 6'b000010, StRead = 6'b000100,
    StShift = 6'b001000, StMac = 6'b010000, StOut = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] rad_q; logic [15:0] wt_q [4]; logic [10:0] fw_q; logic [12:0] fh_q;
  logic [RowW-1:0] row_q; logic [ColW:0] col_q;
  logic [RowW-1:0] crow_q; logic [ColW-1:0] ccol_q;
  logic [7:0] pix_q;
  logic [7:0] win_q [Win][Win];
  logic [ColW:0] clr_q;
  logic [2:0] my_q, mx_q;
  logic [31:0] wprod_q; logic [39:0] prod_q; logic pv_q, pv2_q, mlast_q;
  logic [47:0] acc_q;
  logic [7:0] ob_q; logic [RowW-1:0] orow_q; logic [ColW-1:0] ocol_q; logic olast_q;
  logic ovalid_q;

  logic [1:0] r; logic [2:0] n; logic [10:0] w; logic [12:0] h;
  logic [LineW-1:0] rdata, wdata;
  logic [7:0] col_v [Win];
  logic acc_in;

  always_comb begin
    r = (rad_q == 2'd0) ? 2'd1 : rad_q;
    n = {r, 1'b0};
    w = (fw_q < 11'd16) ? 11'd16 : (fw_q > 11'd1024) ? 11'd1024 : fw_q;
    h = (fh_q < 13'd16) ? 13'd16 : (fh_q > 13'd4096) ? 13'd4096 : fh_q;
  end

  // position computed at acceptance (includes wrap rules)
  logic [RowW:0] prow; logic [ColW:0] pcol;
  always_comb begin
    prow = s_axis_tuser ? '0 : {1'b0, row_q};
    pcol = s_axis_tuser ? '0 : col_q;
    if ({1'b0, pcol} >= {1'b0, w}) begin
      pcol = '0; prow = prow + 1'b1;
    end
    if (prow >= h) prow = '0;
  end

  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  gbw_line_mem u_mem (
    .clk_i, .we_i(state_q == StClr || state_q == StShift),
    .waddr_i(state_q == StClr ? clr_q[ColW-1:0] : ccol_q),
    .wdata_i(state_q == StClr ? '0 : wdata),
    .re_i(acc_in), .raddr_i(pcol[ColW-1:0]), .rdata_o(rdata)
  );

  always_comb begin
    wdata = rdata;
    for (int y = 0; y < Win; y++) col_v[y] = 8'd0;
    for (int y = 0; y < Lines; y++) begin
      if (3'(y) < n) col_v[y] = rdata[8*y +: 8];
      if (3'(y) + 3'd1 < n) wdata[8*y +: 8] = rdata[8*(y+1) +: 8];
      if (3'(y) + 3'd1 == n) wdata[8*y +: 8] = pix_q;
    end
    for (int y = 0; y < Win; y++) if (3'(y) == n) col_v[y] = pix_q;
  end

  logic [1:0] dy, dx;
  always_comb begin
    dy = (my_q >= {1'b0, r}) ? 2'(my_q - r) : 2'(r - my_q);
    dx = (mx_q >= {1'b0, r}) ? 2'(mx_q - r) : 2'(r - mx_q);
  end
  logic mac_end; assign mac_end = (my_q == n) && (mx_q == n);
  logic is_out;
  assign is_out = (crow_q >= RowW'(n)) && ({1'b0, ccol_q} >= (ColW+1)'(n));
  // window tap of the previous MAC step, whose weight product sits in wprod_q
  logic [2:0] wrow, wcol;
  assign wrow = (mx_q == 3'd0 && my_q != 3'd0) ? my_q - 3'd1 : my_q;
  assign wcol = (mx_q == 3'd0) ? n : mx_q - 3'd1;
  // drain done and output register free
  logic out_ld;
  assign out_ld = (state_q == StOut) && !pv_q && !pv2_q && (!ovalid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClr:   if (clr_q == (ColW+1)'(MaxWidth - 1)) state_d = StIdle;
      StIdle:  if (acc_in) state_d = StRead;
      StRead:  state_d = StShift;
      StShift: state_d = is_out ? StMac : StIdle;
      StMac:   if (mac_end) state_d = StOut;
      StOut:   if (out_ld) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr; clr_q <= '0; row_q <= '0; col_q <= '0; ovalid_q <= 1'b0;
      rad_q <= 2'd1; wt_q[0] <= 16'd29615; wt_q[1] <= 16'd17962;
      wt_q[2] <= '0; wt_q[3] <= '0; fw_q <= 11'd640; fh_q <= 13'd480;
      pv_q <= 1'b0; pv2_q <= 1'b0;
      for (int y = 0; y < Win; y++) for (int x = 0; x < Win; x++) win_q[y][x] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClr) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRadius: rad_q <= cfg_data_i[1:0];
          RegW0:     wt_q[0] <= cfg_data_i;
          RegW1:     wt_q[1] <= cfg_data_i;
          RegW2:     wt_q[2] <= cfg_data_i;
          RegW3:     wt_q[3] <= cfg_data_i;
          RegWidth:  fw_q <= cfg_data_i[10:0];
          RegHeight: fh_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (acc_in) begin
        if ({1'b0, pcol} + 12'd1 >= {1'b0, w}) begin
          col_q <= '0;
          row_q <= (prow + 1'b1 >= h) ? '0 : RowW'(prow + 1'b1);
        end else begin
          col_q <= pcol + 1'b1; row_q <= RowW'(prow);
        end
      end
      if (state_q == StShift) begin
        for (int y = 0; y < Win; y++) begin
          if (3'(y) <= n) begin
            for (int x = 0; x < Win - 1; x++)
              if (3'(x) < n) win_q[y][x] <= win_q[y][x+1];
            for (int x = 0; x < Win; x++)
              if (3'(x) == n) win_q[y][x] <= col_v[y];
          end
        end
      end
      pv_q <= (state_q == StMac);
      pv2_q <= pv_q;
      ovalid_q <= out_ld ? 1'b1 : (m_axis_tready ? 1'b0 : ovalid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pix_q <= s_axis_tdata; crow_q <= RowW'(prow); ccol_q <= pcol[ColW-1:0];
    end
    if (state_q == StShift) begin
      my_q <= '0; mx_q <= '0; acc_q <= '0;
      mlast_q <= ({1'b0, crow_q} == h - 13'd1) && ({1'b0, ccol_q} == w - 11'd1);
    end
    if (state_q == StMac) begin
      if (mx_q == n) begin mx_q <= '0; my_q <= my_q + 1'b1; end
      else mx_q <= mx_q + 1'b1;
      wprod_q <= wt_q[dy] * wt_q[dx];
    end
    prod_q <= wprod_q * win_q[wrow][wcol];
    // products pass through wprod_q and prod_q, their valid through pv_q and pv2_q
    if (pv2_q) acc_q <= acc_q + 48'(prod_q);
    if (out_ld) begin
      ob_q <= (acc_q[47:32] > 16'd255) ? 8'd255 : acc_q[39:32];
      orow_q <= crow_q - RowW'(r); ocol_q <= ccol_q - ColW'(r); olast_q <= mlast_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {2'b00, ocol_q, orow_q, ob_q};
  assign m_axis_tlast = olast_q;

  a_ready_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClr) |-> !s_axis_tready) else $error("ready during clear");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> !s_axis_tready) else $error("two words in flight");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
endmodule

// ===== dv/gaussian_blur_window_tb.sv =====
// Self-checking testbench for gaussian_blur_window: streams pixel frames under
// several register settings and checks every blurred word against a predictor.
// Depends on gbw_pkg and the RTL of the block.
module gaussian_blur_window_tb;
  import gbw_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  gaussian_blur_window dut (.*);

  typedef struct {
    logic [7:0]  blurred;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } blur_word_t;

  typedef struct {
    logic [7:0] pixel;
    logic       start;
  } pixel_row_t;

  // predictor copy of registers and stores
  logic [1:0]  p_radius;
  logic [15:0] p_weight [4];
  logic [10:0] p_width;
  logic [12:0] p_height;
  logic [7:0]  p_lines [Lines][MaxWidth];
  logic [7:0]  p_win [Win][Win];
  int unsigned p_row, p_col;

  blur_word_t blur_q[$];
  int         fails = 0;
  int         words_seen = 0;
  bit         hold_done = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic predict_pixel(input logic [7:0] pix, input logic start);
    int unsigned r, n, w, h, row, col;
    logic [7:0] column [Win];
    longint unsigned acc, wy, wx;
    int unsigned dy, dx;
    blur_word_t e;
    r = (p_radius == 0) ? 1 : p_radius;
    n = 2 * r;
    w = (p_width < 16) ? 16 : (p_width > MaxWidth) ? MaxWidth : p_width;
    h = (p_height < 16) ? 16 : (p_height > 4096) ? 4096 : p_height;
    if (start) begin
      p_row = 0;
      p_col = 0;
    end
    if (p_col >= w) begin
      p_col = 0;
      p_row++;
    end
    if (p_row >= h) p_row = 0;
    row = p_row;
    col = p_col;
    for (int y = 0; y < n; y++) column[y] = p_lines[y][col];
    column[n] = pix;
    for (int y = 0; y + 1 < n; y++) p_lines[y][col] = p_lines[y+1][col];
    p_lines[n-1][col] = pix;
    for (int y = 0; y <= n; y++) begin
      for (int x = 0; x < n; x++) p_win[y][x] = p_win[y][x+1];
      p_win[y][n] = column[y];
    end
    if (row >= n && col >= n) begin
      acc = 0;
      for (int y = 0; y <= n; y++) begin
        dy = (y >= r) ? y - r : r - y;
        wy = 64'(p_weight[dy]);
        for (int x = 0; x <= n; x++) begin
          dx = (x >= r) ? x - r : r - x;
          wx = 64'(p_weight[dx]);
          acc += wy * wx * 64'(p_win[y][x]);
        end
      end
      acc = acc >> 32;
      e.blurred = (acc > 255) ? 8'd255 : acc[7:0];
      e.row = 12'(row - r);
      e.col = 10'(col - r);
      e.last = (row == h - 1 && col == w - 1);
      blur_q.push_back(e);
    end
    if (col + 1 >= w) begin
      p_col = 0;
      p_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      p_col = col + 1;
    end
  endtask

  // leaves cfg_we_i high; the caller lowers it after the group of writes
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      RegRadius: p_radius    = data[1:0];
      RegW0:     p_weight[0] = data;
      RegW1:     p_weight[1] = data;
      RegW2:     p_weight[2] = data;
      RegW3:     p_weight[3] = data;
      RegWidth:  p_width     = data[10:0];
      RegHeight: p_height    = data[12:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [1:0] r, input logic [15:0] w0, input logic [15:0] w1,
                       input logic [15:0] w2, input logic [15:0] w3,
                       input logic [10:0] wd, input logic [12:0] ht);
    write_reg(RegRadius, {14'd0, r});
    write_reg(RegW0, w0);
    write_reg(RegW1, w1);
    write_reg(RegW2, w2);
    write_reg(RegW3, w3);
    write_reg(RegWidth, {5'd0, wd});
    write_reg(RegHeight, {3'd0, ht});
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_pixel(input logic [7:0] pix, input logic start, input bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(pix, start);
  endtask

  // mode 0: random, 1: all white (saturation), 2: black/white extremes
  task automatic send_frame(input int count, input bit first_start, input int mode);
    logic [7:0] pix;
    logic       st;
    for (int i = 0; i < count; i++) begin
      case (mode)
        1:       pix = 8'hFF;
        2:       pix = $urandom_range(1) ? 8'hFF : 8'h00;
        default: pix = 8'($urandom_range(255));
      endcase
      st = (i == 0) ? first_start : ($urandom_range(199) == 0);
      send_pixel(pix, st, 1'b1);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // idle: every expected word has arrived, then the pipe drains items with no result
  task automatic settle();
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    blur_word_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (blur_q.size() == 0) begin
        $error("unexpected word tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        fails++;
      end else begin
        e = blur_q.pop_front();
        if (m_axis_tdata[7:0] !== e.blurred) begin
          $error("blurred: expected %0d, actual %0d", e.blurred, m_axis_tdata[7:0]);
          fails++;
        end
        if (m_axis_tdata[19:8] !== e.row) begin
          $error("centre_row: expected %0d, actual %0d", e.row, m_axis_tdata[19:8]);
          fails++;
        end
        if (m_axis_tdata[29:20] !== e.col) begin
          $error("centre_col: expected %0d, actual %0d", e.col, m_axis_tdata[29:20]);
          fails++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && words_seen >= 40) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk_i);
      end
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  end

  pixel_row_t dir_tab [] = '{
    '{8'h00, 1'b1}, '{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0},
    '{8'h55, 1'b0}, '{8'hAA, 1'b0}, '{8'h01, 1'b0}, '{8'h80, 1'b0},
    '{8'h7F, 1'b0}, '{8'hFE, 1'b1}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
    '{8'h00, 1'b0}, '{8'h0F, 1'b0}, '{8'hF0, 1'b0}, '{8'h33, 1'b1},
    '{8'hCC, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h10, 1'b0}
  };

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    p_radius = 1;
    p_weight[0] = 29615; p_weight[1] = 17962; p_weight[2] = 0; p_weight[3] = 0;
    p_width = 640;
    p_height = 480;
    p_row = 0;
    p_col = 0;
    foreach (p_lines[y, x]) p_lines[y][x] = '0;
    foreach (p_win[y, x]) p_win[y][x] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: a 640-wide frame, so none of these rows yields a word
    foreach (dir_tab[i]) send_pixel(dir_tab[i].pixel, dir_tab[i].start, 1'b0);
    s_axis_tvalid <= 1'b0;
    if (blur_q.size() != 0) begin
      $error("blurred: expected no word after reset rows, predictor has %0d", blur_q.size());
      fails++;
    end
    settle();

    // unused index must be ignored
    write_reg(RegNone, 16'hFFFF);
    // radius 0 acts as 1, sizes 0 clamp to 16, full weights saturate;
    // runs past the frame end into an overrun frame
    setup(2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd0, 13'd0);
    send_frame(292, 1'b1, 2);
    settle();
    setup(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          11'd16, 13'd16);
    send_frame(104, 1'b1, 0);
    settle();
    setup(2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 11'd20, 13'd18);
    send_frame(90, 1'b1, 1);
    settle();
    // no frame start: the position runs on under the new width, radius shrinks mid-frame
    setup(2'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          11'd17, 13'd16);
    send_frame(40, 1'b0, 0);
    settle();
    // widest line and tallest frame, clamped
    setup(2'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          11'h7FF, 13'h1FFF);
    send_frame(30, 1'b1, 0);
    settle();

    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== gaussian_blur_window.f =====
design/gbw_pkg.sv
design/gbw_line_mem.sv
design/gaussian_blur_window.sv
dv/gaussian_blur_window_tb.sv
